>>> rtl/tbt_pkg.sv
`default_nettype none

package tbt_pkg;

  // Field widths of the request and result transfers.
  localparam int unsigned START_W = 20;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned OUT_W   = 21;

  // Size of the visited map and the longest request that is honoured.
  localparam int unsigned MAP_BLOCKS     = 1048576;
  localparam int unsigned MAX_REQ_BLOCKS = 4096;

  // Bitmap organisation: one memory word holds the flags of 64 blocks.
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned OFS_W     = $clog2(WORD_BITS);
  localparam int unsigned MAP_WORDS = MAP_BLOCKS / WORD_BITS;
  localparam int unsigned WORD_AW   = $clog2(MAP_WORDS);
  localparam int unsigned POP_W     = $clog2(WORD_BITS + 1);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

>>> rtl/tbt_ram.sv
`default_nettype none

module tbt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbt_merge.sv
`default_nettype none

module tbt_merge (
  input  wire logic [tbt_pkg::WORD_BITS-1:0] old_word,
  input  wire logic [tbt_pkg::OFS_W-1:0]     lo_ofs,
  input  wire logic [tbt_pkg::OFS_W-1:0]     hi_ofs,
  output logic      [tbt_pkg::WORD_BITS-1:0] new_word,
  output logic      [tbt_pkg::POP_W-1:0]     added
);

  localparam int unsigned GROUPS = tbt_pkg::WORD_BITS / 8;

  logic [tbt_pkg::WORD_BITS-1:0] mask;
  logic [tbt_pkg::WORD_BITS-1:0] fresh;
  logic [3:0]                    grp_cnt [GROUPS];

  // Bits lo_ofs up to hi_ofs inclusive are covered within this word.
  assign mask = ({tbt_pkg::WORD_BITS{1'b1}} << lo_ofs)
              & ({tbt_pkg::WORD_BITS{1'b1}} >> (~hi_ofs));
  assign fresh    = mask & ~old_word;
  assign new_word = old_word | mask;

  // Count the newly set bits in groups of eight, then sum the groups.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_cnt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_cnt[g] = grp_cnt[g] + 4'(fresh[g*8 + b]);
      end
    end
  end

  always_comb begin
    added = '0;
    for (int g = 0; g < GROUPS; g++) begin
      added = added + tbt_pkg::POP_W'(grp_cnt[g]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/touched_block_tracker.sv
`default_nettype none

// Working-set tracker. Each request transfer on the input channel (in_valid,
// in_stall, start_block, block_count) names a run of blocks; every covered
// block inside the map is marked in a bitmap held in one 16384 x 64 memory.
// One result transfer per request leaves on the output channel (out_valid,
// out_stall, distinct_blocks, highest_end, out_of_range).
//
// Requests are handled one at a time. For each bitmap word that a request
// spans, the word is read in ST_READ and then merged and written back in
// ST_MODIFY; the count is settled in ST_FLUSH, which loads the result once
// the output register is free, and the sequencer then returns to ST_IDLE to
// take the next request. A request of 4096 blocks touches 64 or 65 words; an
// empty request goes straight from ST_IDLE to ST_FLUSH.
//
// After reset the bitmap is swept clear at one word per cycle, during which
// in_stall is held high. Counters and the high-water mark reset to zero. The
// result sits in an output register; the next request is taken while it
// waits, and that request's result is held back until out_stall falls.
module touched_block_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tbt_pkg::START_W-1:0] start_block,
  input  wire logic [tbt_pkg::COUNT_W-1:0] block_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [tbt_pkg::OUT_W-1:0]   distinct_blocks,
  output logic      [tbt_pkg::OUT_W-1:0]   highest_end,
  output logic                             out_of_range
);

  localparam int unsigned AW  = tbt_pkg::WORD_AW;
  localparam int unsigned OW  = tbt_pkg::OFS_W;
  localparam int unsigned DW  = tbt_pkg::WORD_BITS;
  localparam int unsigned RW  = tbt_pkg::OUT_W;

  tbt_pkg::state_t state, state_next;

  logic [AW-1:0]             clr_addr;
  logic [AW-1:0]             cur_word;
  logic [AW-1:0]             last_word;
  logic [OW-1:0]             first_ofs;
  logic [OW-1:0]             last_ofs;
  logic                      first;
  logic                      beyond;
  logic [RW-1:0]             touched_count;
  logic [RW-1:0]             count_next;
  logic [RW-1:0]             max_end;
  logic [tbt_pkg::POP_W-1:0] pop_q;

  logic                              accept;
  logic [tbt_pkg::COUNT_W-1:0]       len_sat;
  logic [RW-1:0]                     req_end;
  logic [RW-1:0]                     lim;
  logic [RW-1:0]                     last_blk;
  logic                              has_blocks;
  logic                              at_last;
  logic                              out_free;
  logic                              load_result;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [DW-1:0]             ram_wdata;
  logic                      ram_re;
  logic [DW-1:0]             ram_rdata;
  logic [OW-1:0]             lo_ofs;
  logic [OW-1:0]             hi_ofs;
  logic [DW-1:0]             merged;
  logic [tbt_pkg::POP_W-1:0] added;

  // Request decode: saturate the length and find the last block in the map.
  assign len_sat = (block_count > tbt_pkg::COUNT_W'(tbt_pkg::MAX_REQ_BLOCKS))
                 ? tbt_pkg::COUNT_W'(tbt_pkg::MAX_REQ_BLOCKS) : block_count;
  assign req_end = RW'(start_block) + RW'(len_sat);
  assign lim     = (req_end > RW'(tbt_pkg::MAP_BLOCKS))
                 ? RW'(tbt_pkg::MAP_BLOCKS) : req_end;
  assign has_blocks = RW'(start_block) < lim;
  assign last_blk   = lim - RW'(1);

  assign accept     = in_valid && !in_stall;
  assign at_last    = cur_word == last_word;
  assign out_free   = !out_valid || !out_stall;
  assign count_next = touched_count + RW'(pop_q);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      tbt_pkg::ST_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) begin
          state_next = tbt_pkg::ST_IDLE;
        end
      end
      tbt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = has_blocks ? tbt_pkg::ST_READ : tbt_pkg::ST_FLUSH;
        end
      end
      tbt_pkg::ST_READ: begin
        state_next = tbt_pkg::ST_MODIFY;
      end
      tbt_pkg::ST_MODIFY: begin
        state_next = at_last ? tbt_pkg::ST_FLUSH : tbt_pkg::ST_READ;
      end
      tbt_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_next = tbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tbt_pkg::ST_CLEAR;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall    = 1'b1;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur_word;
    ram_wdata   = merged;
    load_result = 1'b0;
    unique case (state)
      tbt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      tbt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      tbt_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      tbt_pkg::ST_MODIFY: begin
        ram_we = 1'b1;
      end
      tbt_pkg::ST_FLUSH: begin
        load_result = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tbt_pkg::ST_CLEAR;
      clr_addr      <= '0;
      touched_count <= '0;
      max_end       <= '0;
      pop_q         <= '0;
    end else begin
      state         <= state_next;
      touched_count <= count_next;
      pop_q         <= (state == tbt_pkg::ST_MODIFY) ? added : '0;
      if (state == tbt_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept && req_end > max_end) begin
        max_end <= req_end;
      end
    end
  end

  // Word cursor and the bounds of the current request.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_word  <= start_block[OW +: AW];
      first_ofs <= start_block[OW-1:0];
      last_word <= last_blk[OW +: AW];
      last_ofs  <= last_blk[OW-1:0];
      first     <= 1'b1;
      beyond    <= req_end > RW'(tbt_pkg::MAP_BLOCKS);
    end else if (state == tbt_pkg::ST_MODIFY) begin
      cur_word <= cur_word + AW'(1);
      first    <= 1'b0;
    end
  end

  // Bit range covered within the word being merged.
  assign lo_ofs = first   ? first_ofs : '0;
  assign hi_ofs = at_last ? last_ofs  : {OW{1'b1}};

  tbt_ram #(
    .WIDTH (DW),
    .DEPTH (tbt_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_word),
    .rdata (ram_rdata)
  );

  tbt_merge u_merge (
    .old_word (ram_rdata),
    .lo_ofs   (lo_ofs),
    .hi_ofs   (hi_ofs),
    .new_word (merged),
    .added    (added)
  );

  // Output register: holds the result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      distinct_blocks <= count_next;
      highest_end     <= max_end;
      out_of_range    <= beyond;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbt_checker.sv
`default_nettype none

module tbt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [tbt_pkg::OUT_W-1:0]   distinct_blocks,
  input wire logic [tbt_pkg::OUT_W-1:0]   highest_end,
  input wire logic                        out_of_range
);

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // No result is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented after reset");

  // Requests are taken one at a time: an accepted request makes the block busy.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before the first was processed");

  // A request that ran past the map has raised the high-water mark beyond it.
  a_range_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |->
      highest_end > tbt_pkg::OUT_W'(tbt_pkg::MAP_BLOCKS))
    else $error("out-of-range flag without a high end beyond the map");

  // The distinct-block count can never exceed the map size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distinct_blocks <= tbt_pkg::OUT_W'(tbt_pkg::MAP_BLOCKS))
    else $error("distinct block count beyond the map size");

endmodule

bind touched_block_tracker tbt_checker u_tbt_checker (.*);

`default_nettype wire
